// File: src/uvsg_pkg.sv
// Shared constants, tables, register indexes and a helper function of the UV-sphere vertex generator.
`timescale 1ns / 1ps
`default_nettype none
package uvsg_pkg;

   localparam int IDX_W      = 11;
   localparam int COORD_W    = 32;
   localparam int RAD_W      = 31;
   localparam int TEX_W      = 17;
   localparam int ANGLE_W    = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int FRAC_BITS  = 16;
   localparam int MAX_SLICES = 1024;
   localparam int RESET_SLICES = 30;
   localparam int RESET_RADIUS = 65536;

   // CORDIC datapath: Q2.30 core with guard bits, Q.16 results.
   localparam int CORE_BITS = 30;
   localparam int CORE_W    = 34;
   localparam int ZETA_W    = 33;
   localparam int TRIG_W    = 18;
   localparam int MAX_CORDIC_STAGES = 30;
   localparam int CORDIC_STAGES_DEF = 18;
   localparam logic signed [CORE_W-1:0] GAIN_Q30 = 34'sd652032874;

   // Angle arctangents in 2^-32 turn.
   localparam logic [31:0] ATAN_TURNS [MAX_CORDIC_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41721,
      32'd20860, 32'd10430, 32'd5215, 32'd2607, 32'd1303,
      32'd651, 32'd325, 32'd162, 32'd81, 32'd40,
      32'd20, 32'd10, 32'd5, 32'd2, 32'd1
   };

   // Divider: fraction bits of the two angles and radix-2 steps per stage.
   localparam int THETA_FRAC = 32;
   localparam int PHI_FRAC   = 31;
   localparam int DIV_BPS    = 4;
   localparam int DIV_STAGES = (THETA_FRAC + DIV_BPS - 1) / DIV_BPS;

   localparam int SUM_W = 35;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_THETA_SLICES = 3'd0,
      CSR_PHI_SLICES   = 3'd1,
      CSR_CENTER_X     = 3'd2,
      CSR_CENTER_Y     = 3'd3,
      CSR_CENTER_Z     = 3'd4,
      CSR_RADIUS       = 3'd5
   } csr_index_type;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = 35'sd2147483647;
      lo = -35'sd2147483648;
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage
`default_nettype wire

// File: src/uvsg_divider.sv
// Pipelined restoring divider giving index over slice count as a fixed-point fraction.
`timescale 1ns / 1ps
`default_nettype none
module uvsg_divider #(
   parameter int FRAC = 32
) (
   input  wire logic                      clock,
   input  wire logic                      en,
   input  wire logic [uvsg_pkg::IDX_W-1:0] num,
   input  wire logic [uvsg_pkg::IDX_W-1:0] den,
   output logic [FRAC:0]                   quot
);
   import uvsg_pkg::*;

   localparam int NST = DIV_STAGES;

   logic [IDX_W-1:0] rem_src [NST];
   logic [FRAC:0]    q_src   [NST];
   logic [IDX_W-1:0] rem_ff  [NST-1];
   logic [FRAC:0]    q_ff    [NST];

   for (genvar s = 0; s < NST; s++) begin : g_stage
      logic [IDX_W:0] r_c;
      logic [FRAC:0]  q_c;

      if (s == 0) begin : g_head
         // The index never exceeds the count, so the integer part is one bit.
         assign rem_src[s] = (num == den) ? '0 : num;
         assign q_src[s]   = {{FRAC{1'b0}}, (num == den)};
      end else begin : g_body
         assign rem_src[s] = rem_ff[s-1];
         assign q_src[s]   = q_ff[s-1];
      end

      always_comb begin
         r_c = {1'b0, rem_src[s]};
         q_c = q_src[s];
         for (int k = 0; k < DIV_BPS; k++) begin
            if (s * DIV_BPS + k < FRAC) begin
               r_c = {r_c[IDX_W-1:0], 1'b0};
               if (r_c >= {1'b0, den}) begin
                  r_c = r_c - {1'b0, den};
                  q_c = {q_c[FRAC-1:0], 1'b1};
               end else begin
                  q_c = {q_c[FRAC-1:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            q_ff[s] <= q_c;
         end
      end

      if (s < NST - 1) begin : g_rem
         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[s] <= r_c[IDX_W-1:0];
            end
         end
      end
   end

   assign quot = q_ff[NST-1];

endmodule
`default_nettype wire

// File: src/uvsg_cordic.sv
// Pipelined rotation-mode CORDIC giving sine and cosine of a turn fraction.
`timescale 1ns / 1ps
`default_nettype none
module uvsg_cordic #(
   parameter int STAGES = uvsg_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              en,
   input  wire logic [uvsg_pkg::ANGLE_W-1:0]      angle,
   output logic signed [uvsg_pkg::TRIG_W-1:0]     sin_q,
   output logic signed [uvsg_pkg::TRIG_W-1:0]     cos_q
);
   import uvsg_pkg::*;

   localparam int SH = CORE_BITS - FRAC_BITS;
   localparam logic signed [ZETA_W-1:0] QUARTER = 33'sd1073741824;
   localparam logic signed [ZETA_W-1:0] HALF    = 33'sd2147483648;
   localparam logic signed [CORE_W-1:0] RND     = CORE_W'(1) <<< (SH - 1);

   logic signed [CORE_W-1:0] x_ff [STAGES+1];
   logic signed [CORE_W-1:0] y_ff [STAGES+1];
   logic signed [ZETA_W-1:0] z_ff [STAGES];
   logic                     neg_ff [STAGES+1];
   logic signed [ZETA_W-1:0] z_fold;
   logic                     neg_fold;
   logic signed [CORE_W-1:0] xo, yo, xr, yr;

   // Fold the angle into a quarter turn each side of zero; the half turn
   // taken out becomes a sign flip of both results.
   always_comb begin
      z_fold   = signed'({angle[ANGLE_W-1], angle});
      neg_fold = 1'b0;
      if (z_fold > QUARTER) begin
         z_fold   = z_fold - HALF;
         neg_fold = 1'b1;
      end else if (z_fold < -QUARTER) begin
         z_fold   = z_fold + HALF;
         neg_fold = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0]   <= GAIN_Q30;
         y_ff[0]   <= '0;
         z_ff[0]   <= z_fold;
         neg_ff[0] <= neg_fold;
      end
   end

   for (genvar i = 0; i < STAGES; i++) begin : g_iter
      localparam logic signed [ZETA_W-1:0] ATAN = signed'({1'b0, ATAN_TURNS[i]});
      logic signed [CORE_W-1:0] xs, ys;
      assign xs = x_ff[i] >>> i;
      assign ys = y_ff[i] >>> i;

      always_ff @(posedge clock) begin
         if (en) begin
            neg_ff[i+1] <= neg_ff[i];
            if (!z_ff[i][ZETA_W-1]) begin
               x_ff[i+1] <= x_ff[i] - ys;
               y_ff[i+1] <= y_ff[i] + xs;
            end else begin
               x_ff[i+1] <= x_ff[i] + ys;
               y_ff[i+1] <= y_ff[i] - xs;
            end
         end
      end

      if (i < STAGES - 1) begin : g_z
         always_ff @(posedge clock) begin
            if (en) begin
               z_ff[i+1] <= z_ff[i][ZETA_W-1] ? z_ff[i] + ATAN : z_ff[i] - ATAN;
            end
         end
      end
   end

   always_comb begin
      xo = neg_ff[STAGES] ? -x_ff[STAGES] : x_ff[STAGES];
      yo = neg_ff[STAGES] ? -y_ff[STAGES] : y_ff[STAGES];
      xr = (xo + RND) >>> SH;
      yr = (yo + RND) >>> SH;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cos_q <= xr[TRIG_W-1:0];
         sin_q <= yr[TRIG_W-1:0];
      end
   end

endmodule
`default_nettype wire

// File: src/uv_sphere_vertex_generator.sv
// Top level of the UV-sphere vertex generator: registers, pipeline control and vertex math.
`timescale 1ns / 1ps
`default_nettype none
// Usage: each req_ transaction carries a latitude and a longitude grid index. The block
// answers with one rsp_ transaction holding the vertex position, the inward vector
// from the vertex to the center, and the texture coordinates of that grid point.
// Indices above the configured slice count are clamped to the count.
// The csr_ port writes the slice counts, center and radius; it is
// meant to be used only while no transaction is in flight.
// Throughput is one transaction per clock while the receiver does not stall. The stages
// are eight divider stages of four quotient bits, one fold stage, one stage per
// CORDIC iteration, one rounding stage, and six stages of products, rounding,
// center add with saturation and the normal subtraction.
// The whole pipeline moves on one enable: it advances whenever the output register
// is empty or being taken. When the receiver stalls with a result waiting, every
// stage holds and req_ready drops, so nothing is lost or repeated.
// Reset (synchronous) empties the pipeline and loads 30 slices each way, center at
// the origin and radius one.
module uv_sphere_vertex_generator #(
   parameter int CORDIC_STAGES = uvsg_pkg::CORDIC_STAGES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [uvsg_pkg::IDX_W-1:0]            req_lat_index,
   input  wire logic [uvsg_pkg::IDX_W-1:0]            req_lon_index,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_pos_x,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_pos_y,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_pos_z,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_norm_x,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_norm_y,
   output logic signed [uvsg_pkg::COORD_W-1:0]        rsp_norm_z,
   output logic [uvsg_pkg::TEX_W-1:0]                 rsp_tex_u,
   output logic [uvsg_pkg::TEX_W-1:0]                 rsp_tex_v,
   input  wire logic                                  csr_we,
   input  wire logic [uvsg_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  wire logic [uvsg_pkg::COORD_W-1:0]          csr_wdata
);
   import uvsg_pkg::*;

   // Pipeline depth after the dividers and over the whole block.
   localparam int TAIL    = CORDIC_STAGES + 8;
   localparam int LATENCY = DIV_STAGES + TAIL;
   localparam int PROD_W  = 2 * TRIG_W;
   localparam int RPROD_W = COORD_W + TRIG_W;
   localparam int RSH_W   = RPROD_W - FRAC_BITS;
   localparam logic signed [PROD_W-1:0]  RND_P = PROD_W'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [RPROD_W-1:0] RND_R = RPROD_W'(1) <<< (FRAC_BITS - 1);

   // ---------------------------------------------------------------------------
   // Configuration registers. A zero slice count is ignored, a large one clamps.
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]          theta_slices_ff, phi_slices_ff;
   logic signed [COORD_W-1:0] center_x_ff, center_y_ff, center_z_ff;
   logic [RAD_W-1:0]          radius_ff;
   logic [IDX_W-1:0]          wslice;
   logic                      wslice_ok;
   logic [IDX_W-1:0]          wslice_sat;

   assign wslice     = csr_wdata[IDX_W-1:0];
   assign wslice_ok  = (wslice != '0);
   assign wslice_sat = (wslice > IDX_W'(MAX_SLICES)) ? IDX_W'(MAX_SLICES) : wslice;

   always_ff @(posedge clock) begin
      if (reset) begin
         theta_slices_ff <= IDX_W'(RESET_SLICES);
         phi_slices_ff   <= IDX_W'(RESET_SLICES);
         center_x_ff     <= '0;
         center_y_ff     <= '0;
         center_z_ff     <= '0;
         radius_ff       <= RAD_W'(RESET_RADIUS);
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_THETA_SLICES: begin
               if (wslice_ok) theta_slices_ff <= wslice_sat;
            end
            CSR_PHI_SLICES: begin
               if (wslice_ok) phi_slices_ff <= wslice_sat;
            end
            CSR_CENTER_X: center_x_ff <= csr_wdata;
            CSR_CENTER_Y: center_y_ff <= csr_wdata;
            CSR_CENTER_Z: center_z_ff <= csr_wdata;
            CSR_RADIUS:   radius_ff   <= csr_wdata[RAD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------------
   // Pipeline control: a single enable and a valid bit per stage.
   // ---------------------------------------------------------------------------
   logic             en;
   logic [LATENCY-1:0] vld_ff;

   assign en        = !vld_ff[LATENCY-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = vld_ff[LATENCY-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LATENCY-2:0], req_valid};
      end
   end

   // ---------------------------------------------------------------------------
   // Angles. The divider gives the index over the count as a binary fraction;
   // the texture coordinates are its upper bits.
   // ---------------------------------------------------------------------------
   logic [IDX_W-1:0]      lat_sat, lon_sat;
   logic [THETA_FRAC:0]   theta_q;
   logic [PHI_FRAC:0]     phi_q;
   logic [ANGLE_W-1:0]    theta_ang, phi_ang;

   assign lat_sat = (req_lat_index > phi_slices_ff)   ? phi_slices_ff   : req_lat_index;
   assign lon_sat = (req_lon_index > theta_slices_ff) ? theta_slices_ff : req_lon_index;

   uvsg_divider #(.FRAC(THETA_FRAC)) u_div_theta (
      .clock (clock),
      .en    (en),
      .num   (lon_sat),
      .den   (theta_slices_ff),
      .quot  (theta_q)
   );

   uvsg_divider #(.FRAC(PHI_FRAC)) u_div_phi (
      .clock (clock),
      .en    (en),
      .num   (lat_sat),
      .den   (phi_slices_ff),
      .quot  (phi_q)
   );

   // A full turn wraps to zero by dropping the integer bit; latitude starts at
   // minus a quarter turn.
   assign theta_ang = theta_q[ANGLE_W-1:0];
   assign phi_ang   = phi_q[ANGLE_W-1:0] - ANGLE_W'(32'h4000_0000);

   logic [TEX_W-1:0] tex_u_ff [TAIL];
   logic [TEX_W-1:0] tex_v_ff [TAIL];

   always_ff @(posedge clock) begin
      if (en) begin
         tex_u_ff[0] <= theta_q[THETA_FRAC -: TEX_W];
         tex_v_ff[0] <= phi_q[PHI_FRAC -: TEX_W];
         for (int i = 1; i < TAIL; i++) begin
            tex_u_ff[i] <= tex_u_ff[i-1];
            tex_v_ff[i] <= tex_v_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sine and cosine of both angles.
   // ---------------------------------------------------------------------------
   logic signed [TRIG_W-1:0] sin_t, cos_t, sin_p, cos_p;

   uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_theta (
      .clock (clock),
      .en    (en),
      .angle (theta_ang),
      .sin_q (sin_t),
      .cos_q (cos_t)
   );

   uvsg_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_phi (
      .clock (clock),
      .en    (en),
      .angle (phi_ang),
      .sin_q (sin_p),
      .cos_q (cos_p)
   );

   // ---------------------------------------------------------------------------
   // Vertex math, six stages: trig products, rounding, radius products,
   // rounding, center add with saturation, normal.
   // ---------------------------------------------------------------------------
   logic signed [PROD_W-1:0]  pcc_ff, psc_ff;
   logic signed [TRIG_W-1:0]  sp1_ff, sp2_ff, cc_ff, sc_ff;
   logic signed [PROD_W-1:0]  pcc_r, psc_r;
   logic signed [RPROD_W-1:0] rx_ff, ry_ff, rz_ff;
   logic signed [RPROD_W-1:0] rx_r, ry_r, rz_r;
   logic signed [RSH_W-1:0]   ox_ff, oy_ff, oz_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pz_ff;
   logic signed [COORD_W:0]   rad_s;

   assign pcc_r = (pcc_ff + RND_P) >>> FRAC_BITS;
   assign psc_r = (psc_ff + RND_P) >>> FRAC_BITS;
   assign rad_s = signed'({2'b00, radius_ff});
   assign rx_r  = (rx_ff + RND_R) >>> FRAC_BITS;
   assign ry_r  = (ry_ff + RND_R) >>> FRAC_BITS;
   assign rz_r  = (rz_ff + RND_R) >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (en) begin
         pcc_ff <= cos_t * cos_p;
         psc_ff <= sin_t * cos_p;
         sp1_ff <= sin_p;

         cc_ff  <= pcc_r[TRIG_W-1:0];
         sc_ff  <= psc_r[TRIG_W-1:0];
         sp2_ff <= sp1_ff;

         rx_ff  <= RPROD_W'(rad_s * cc_ff);
         ry_ff  <= RPROD_W'(rad_s * sp2_ff);
         rz_ff  <= RPROD_W'(rad_s * sc_ff);

         ox_ff  <= rx_r[RSH_W-1:0];
         oy_ff  <= ry_r[RSH_W-1:0];
         oz_ff  <= rz_r[RSH_W-1:0];

         px_ff  <= sat32(SUM_W'(center_x_ff) + SUM_W'(ox_ff));
         py_ff  <= sat32(SUM_W'(center_y_ff) + SUM_W'(oy_ff));
         pz_ff  <= sat32(SUM_W'(center_z_ff) + SUM_W'(oz_ff));

         // Output register: position and the vector back to the center.
         rsp_pos_x  <= px_ff;
         rsp_pos_y  <= py_ff;
         rsp_pos_z  <= pz_ff;
         rsp_norm_x <= sat32(SUM_W'(center_x_ff) - SUM_W'(px_ff));
         rsp_norm_y <= sat32(SUM_W'(center_y_ff) - SUM_W'(py_ff));
         rsp_norm_z <= sat32(SUM_W'(center_z_ff) - SUM_W'(pz_ff));
      end
   end

   assign rsp_tex_u = tex_u_ff[TAIL-1];
   assign rsp_tex_v = tex_v_ff[TAIL-1];

   // ---------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_follows_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow the output stall");

   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_tex_u <= TEX_W'(65536) && rsp_tex_v <= TEX_W'(65536)))
      else $error("texture coordinate above one");

   a_slices_nonzero: assert property (@(posedge clock) disable iff (reset)
      theta_slices_ff != '0 && phi_slices_ff != '0)
      else $error("slice count is zero");

endmodule
`default_nettype wire
